[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL of the harmonic bond force block (the back part).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_RST(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error("assertion failed");
`define CHK_ALL(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("assertion failed");
`else
`define CHK_RST(lbl, ck, rs, prop)
`define CHK_ALL(lbl, ck, prop)
`endif
`endif

[hw/rtl/hbf_pkg.sv]
// Types and constants of the harmonic bond force block.
package hbf_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int LAMBDA_FRAC = 16;
  localparam int E_SHIFT     = 2 * FRAC_BITS + 1;
  localparam int F_SHIFT     = 2 * FRAC_BITS + LAMBDA_FRAC;
  localparam int DW    = 33;
  localparam int BW    = 34;
  localparam int CW    = 34;
  localparam int PW    = 2 * CW;
  localparam int QW    = 35;
  localparam int NUMW  = BW + F_SHIFT + QW - 1;
  localparam int ACCW  = NUMW + 1;
  localparam int SQW   = 67;
  localparam int SQ_STEPS = 34;
  localparam int CNTW  = 6;
  localparam int OUTW  = 48;
  localparam int LW    = 17;

  localparam logic [CNTW-1:0] SQ_CNT0  = CNTW'(SQ_STEPS - 1);
  localparam logic [CNTW-1:0] DIV_CNT0 = CNTW'(QW - 1);
  localparam logic [LW-1:0]   LAMBDA_RESET = LW'(1 << LAMBDA_FRAC);
  localparam logic            REG_LAMBDA = 1'b0;

  typedef struct packed {
    logic [2:0][DW-1:0] ad;
    logic [2:0]         sg;
    logic [31:0]        kb;
    logic [31:0]        b0;
    logic               active;
    logic               last;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_A, ST_MUL_B, ST_SQRT, ST_DIV, ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_DXX, OP_DYY, OP_DZZ, OP_DB2, OP_E_LO, OP_E_HI, OP_DBL, OP_B_LO, OP_B_HI,
    OP_NX0, OP_NX1, OP_NX2, OP_NY0, OP_NY1, OP_NY2, OP_NZ0, OP_NZ1, OP_NZ2
  } op_t;

  typedef enum logic [1:0] {SH_0, SH_1W, SH_2W} shift_t;

endpackage

[hw/rtl/hbf_front.sv]
// Front part: takes bonds, forms coordinate differences and classifies them.
module hbf_front (
  input  logic               push,
  input  logic               q_full,
  input  logic signed [31:0] xi,
  input  logic signed [31:0] yi,
  input  logic signed [31:0] zi,
  input  logic signed [31:0] xj,
  input  logic signed [31:0] yj,
  input  logic signed [31:0] zj,
  input  logic [31:0]        spring_const,
  input  logic [31:0]        rest_length,
  input  logic               active,
  input  logic               last_bond,
  output logic               q_push,
  output hbf_pkg::entry_t    q_entry
);

  logic [2:0][hbf_pkg::DW-1:0] diff;

  always_comb begin
    diff[0] = {xj[31], xj} - {xi[31], xi};
    diff[1] = {yj[31], yj} - {yi[31], yi};
    diff[2] = {zj[31], zj} - {zi[31], zi};
    for (int k = 0; k < 3; k++) begin
      q_entry.sg[k] = diff[k][hbf_pkg::DW-1];
      q_entry.ad[k] = diff[k][hbf_pkg::DW-1] ? (~diff[k] + 1'b1) : diff[k];
    end
    q_entry.kb     = spring_const;
    q_entry.b0     = rest_length;
    q_entry.active = active;
    q_entry.last   = last_bond;
  end

  assign q_push = push && !q_full;

endmodule

[hw/rtl/hbf_queue.sv]
// Two-entry queue between the front and the back part.
module hbf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  hbf_pkg::entry_t wdata,
  input  logic            rd,
  output hbf_pkg::entry_t rdata,
  output logic            full,
  output logic            valid
);

  hbf_pkg::entry_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= !wptr;
      end
      if (rd) begin
        rptr <= !rptr;
      end
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wdata;
    end
  end

  assign rdata = slots[rptr];
  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);

endmodule

[hw/rtl/hbf_back.sv]
// Back part: multiplier sequence, square root, division lanes and result register.
`include "assert_macros.svh"
module hbf_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  hbf_pkg::entry_t                 q_entry,
  output logic                            q_pop,
  input  logic [hbf_pkg::LW-1:0]          lambda_weight,
  input  logic                            pop,
  output logic                            empty,
  output logic signed [hbf_pkg::OUTW-1:0] force_x,
  output logic signed [hbf_pkg::OUTW-1:0] force_y,
  output logic signed [hbf_pkg::OUTW-1:0] force_z,
  output logic [hbf_pkg::OUTW-1:0]        bond_energy,
  output logic [hbf_pkg::OUTW-1:0]        energy_total,
  output logic                            done_res
);

  hbf_pkg::state_t state, state_next;
  hbf_pkg::op_t    op;
  hbf_pkg::entry_t cur;
  hbf_pkg::shift_t msh;

  logic [hbf_pkg::CNTW-1:0] cnt;
  logic [hbf_pkg::CW-1:0]   ma, mb;
  logic                     mclr;
  logic [hbf_pkg::PW-1:0]   prod;
  logic [hbf_pkg::ACCW-1:0] acc, acc_add, acc_new, e_full;
  logic [82:0]              tmp;
  logic [hbf_pkg::SQW-1:0]  rem_sq, res, one, trial;
  logic [hbf_pkg::NUMW-1:0] dsh;
  logic [hbf_pkg::NUMW-1:0] rem [3];
  logic [hbf_pkg::QW-1:0]   quo [3];
  logic [hbf_pkg::OUTW-1:0] ener, energy_sum, sum_sat, total;
  logic [hbf_pkg::OUTW:0]   sum_wide;
  logic [hbf_pkg::BW:0]     db;
  logic [hbf_pkg::BW-1:0]   dbm;
  logic                     neg_db, b_zero, out_valid, res_wr;
  logic [hbf_pkg::OUTW-1:0] fk [3];

  always_comb begin
    db     = {1'b0, res[hbf_pkg::BW-1:0]} - {3'b0, cur.b0};
    neg_db = db[hbf_pkg::BW];
    dbm    = neg_db ? hbf_pkg::BW'(~db + 1'b1) : db[hbf_pkg::BW-1:0];
    b_zero = (res[hbf_pkg::BW-1:0] == '0);
  end

  always_comb begin
    ma   = '0;
    mb   = '0;
    msh  = hbf_pkg::SH_0;
    mclr = 1'b0;
    unique case (op)
      hbf_pkg::OP_DXX: begin
        ma = 34'(cur.ad[0]); mb = 34'(cur.ad[0]); mclr = 1'b1;
      end
      hbf_pkg::OP_DYY: begin
        ma = 34'(cur.ad[1]); mb = 34'(cur.ad[1]);
      end
      hbf_pkg::OP_DZZ: begin
        ma = 34'(cur.ad[2]); mb = 34'(cur.ad[2]);
      end
      hbf_pkg::OP_DB2: begin
        ma = dbm; mb = dbm; mclr = 1'b1;
      end
      hbf_pkg::OP_E_LO, hbf_pkg::OP_B_LO: begin
        ma = tmp[33:0]; mb = 34'(cur.kb); mclr = 1'b1;
      end
      hbf_pkg::OP_E_HI, hbf_pkg::OP_B_HI: begin
        ma = tmp[67:34]; mb = 34'(cur.kb); msh = hbf_pkg::SH_1W;
      end
      hbf_pkg::OP_DBL: begin
        ma = dbm; mb = 34'(lambda_weight); mclr = 1'b1;
      end
      hbf_pkg::OP_NX0: begin
        ma = tmp[33:0]; mb = 34'(cur.ad[0]); mclr = 1'b1;
      end
      hbf_pkg::OP_NX1: begin
        ma = tmp[67:34]; mb = 34'(cur.ad[0]); msh = hbf_pkg::SH_1W;
      end
      hbf_pkg::OP_NX2: begin
        ma = 34'(tmp[82:68]); mb = 34'(cur.ad[0]); msh = hbf_pkg::SH_2W;
      end
      hbf_pkg::OP_NY0: begin
        ma = tmp[33:0]; mb = 34'(cur.ad[1]); mclr = 1'b1;
      end
      hbf_pkg::OP_NY1: begin
        ma = tmp[67:34]; mb = 34'(cur.ad[1]); msh = hbf_pkg::SH_1W;
      end
      hbf_pkg::OP_NY2: begin
        ma = 34'(tmp[82:68]); mb = 34'(cur.ad[1]); msh = hbf_pkg::SH_2W;
      end
      hbf_pkg::OP_NZ0: begin
        ma = tmp[33:0]; mb = 34'(cur.ad[2]); mclr = 1'b1;
      end
      hbf_pkg::OP_NZ1: begin
        ma = tmp[67:34]; mb = 34'(cur.ad[2]); msh = hbf_pkg::SH_1W;
      end
      hbf_pkg::OP_NZ2: begin
        ma = 34'(tmp[82:68]); mb = 34'(cur.ad[2]); msh = hbf_pkg::SH_2W;
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  always_comb begin
    case (msh)
      hbf_pkg::SH_1W: acc_add = hbf_pkg::ACCW'(prod) << hbf_pkg::CW;
      hbf_pkg::SH_2W: acc_add = hbf_pkg::ACCW'(prod) << (2 * hbf_pkg::CW);
      default:        acc_add = hbf_pkg::ACCW'(prod);
    endcase
    acc_new = (mclr ? '0 : acc) + acc_add;
    e_full  = acc_new >> hbf_pkg::E_SHIFT;
    trial   = res + one;
  end

  always_comb begin
    sum_wide = {1'b0, energy_sum} + {1'b0, ener};
    sum_sat  = sum_wide[hbf_pkg::OUTW] ? '1 : sum_wide[hbf_pkg::OUTW-1:0];
    total    = cur.active ? sum_sat : energy_sum;
    for (int k = 0; k < 3; k++) begin
      if (quo[k] == '0) begin
        fk[k] = '0;
      end else if (neg_db ^ cur.sg[k]) begin
        fk[k] = ~hbf_pkg::OUTW'(quo[k]) + 1'b1;
      end else begin
        fk[k] = hbf_pkg::OUTW'(quo[k]);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hbf_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = q_entry.active ? hbf_pkg::ST_MUL_A : hbf_pkg::ST_FIN;
        end
      end
      hbf_pkg::ST_MUL_A: state_next = hbf_pkg::ST_MUL_B;
      hbf_pkg::ST_MUL_B: begin
        if (op == hbf_pkg::OP_DZZ) begin
          state_next = hbf_pkg::ST_SQRT;
        end else if (op == hbf_pkg::OP_E_HI && b_zero) begin
          state_next = hbf_pkg::ST_FIN;
        end else if (op == hbf_pkg::OP_NZ2) begin
          state_next = hbf_pkg::ST_DIV;
        end else begin
          state_next = hbf_pkg::ST_MUL_A;
        end
      end
      hbf_pkg::ST_SQRT: begin
        if (cnt == '0) begin
          state_next = hbf_pkg::ST_MUL_A;
        end
      end
      hbf_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = hbf_pkg::ST_FIN;
        end
      end
      hbf_pkg::ST_FIN: begin
        if (!out_valid) begin
          state_next = hbf_pkg::ST_IDLE;
        end
      end
      default: state_next = hbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = (state == hbf_pkg::ST_IDLE) && q_valid;
    res_wr = (state == hbf_pkg::ST_FIN) && !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hbf_pkg::ST_IDLE;
      out_valid  <= 1'b0;
      energy_sum <= '0;
    end else begin
      state <= state_next;
      if (res_wr) begin
        out_valid  <= 1'b1;
        energy_sum <= cur.last ? '0 : total;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      hbf_pkg::ST_IDLE: begin
        cur  <= q_entry;
        op   <= hbf_pkg::OP_DXX;
        ener <= '0;
        res  <= '0;
        for (int k = 0; k < 3; k++) begin
          quo[k] <= '0;
        end
      end
      hbf_pkg::ST_MUL_A: begin
        prod <= ma * mb;
      end
      hbf_pkg::ST_MUL_B: begin
        acc <= acc_new;
        op  <= hbf_pkg::op_t'(op + 1'b1);
        case (op)
          hbf_pkg::OP_DZZ: begin
            rem_sq <= acc_new[hbf_pkg::SQW-1:0];
            res    <= '0;
            one    <= hbf_pkg::SQW'(1) << (2 * (hbf_pkg::SQ_STEPS - 1));
            cnt    <= hbf_pkg::SQ_CNT0;
          end
          hbf_pkg::OP_DB2, hbf_pkg::OP_DBL, hbf_pkg::OP_B_HI: begin
            tmp <= acc_new[82:0];
          end
          hbf_pkg::OP_E_HI: begin
            ener <= (e_full[hbf_pkg::ACCW-1:hbf_pkg::OUTW] != '0) ? '1
                    : e_full[hbf_pkg::OUTW-1:0];
          end
          hbf_pkg::OP_NX2: rem[0] <= acc_new[hbf_pkg::NUMW-1:0];
          hbf_pkg::OP_NY2: rem[1] <= acc_new[hbf_pkg::NUMW-1:0];
          hbf_pkg::OP_NZ2: begin
            rem[2] <= acc_new[hbf_pkg::NUMW-1:0];
            dsh    <= hbf_pkg::NUMW'(res[hbf_pkg::BW-1:0]) << (hbf_pkg::NUMW - hbf_pkg::BW);
            cnt    <= hbf_pkg::DIV_CNT0;
          end
          default: begin
            tmp <= tmp;
          end
        endcase
      end
      hbf_pkg::ST_SQRT: begin
        if (rem_sq >= trial) begin
          rem_sq <= rem_sq - trial;
          res    <= (res >> 1) + one;
        end else begin
          res <= res >> 1;
        end
        one <= one >> 2;
        cnt <= cnt - 1'b1;
      end
      hbf_pkg::ST_DIV: begin
        for (int k = 0; k < 3; k++) begin
          if (rem[k] >= dsh) begin
            rem[k] <= rem[k] - dsh;
            quo[k] <= {quo[k][hbf_pkg::QW-2:0], 1'b1};
          end else begin
            quo[k] <= {quo[k][hbf_pkg::QW-2:0], 1'b0};
          end
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
      end
      hbf_pkg::ST_FIN: begin
        if (res_wr) begin
          force_x      <= fk[0];
          force_y      <= fk[1];
          force_z      <= fk[2];
          bond_energy  <= ener;
          energy_total <= total;
          done_res     <= cur.last;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  assign empty = !out_valid;

  `CHK_ALL(a_reset_idle, clk, rst |=> (state == hbf_pkg::ST_IDLE) && !out_valid)
  `CHK_RST(a_sum_hold, clk, rst, !res_wr |=> $stable(energy_sum))
  `CHK_RST(a_root_range, clk, rst, (state == hbf_pkg::ST_SQRT) && (cnt == '0) |=> res[hbf_pkg::SQW-1:hbf_pkg::BW] == '0)
  `CHK_RST(a_div_align, clk, rst, (state == hbf_pkg::ST_DIV) && (cnt == hbf_pkg::DIV_CNT0) |-> dsh[hbf_pkg::NUMW-hbf_pkg::BW-1:0] == '0)

endmodule

[hw/rtl/harmonic_bond_force.sv]
// Top level of the harmonic bond force block: register port, front, queue and back.
//
//  channel  | handshake        | beat
//  ---------+------------------+-----------------------------------------------
//  bonds    | push / full      | xi yi zi xj yj zj spring_const rest_length ...
//  results  | empty / pop      | force_x force_y force_z bond_energy ... done_res
//  config   | psel penable ... | lambda_weight at byte address 0
//
// An active bond with nonzero distance passes in the back part through 18 products on one
// 34 by 34 multiplier, 34 square root steps, 35 steps of the three division lanes, and the
// states that take the bond and write the result. An inactive bond goes straight from
// taking it to writing the result; a zero distance skips the force products and division.
// Reset empties the queue and the result register, clears the energy sum and sets lambda to one.
// The front keeps taking bonds into the two-entry queue, while it is not full, as the back part
// works or a result beat waits to be popped.
module harmonic_bond_force (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] xi,
  input  logic signed [31:0] yi,
  input  logic signed [31:0] zi,
  input  logic signed [31:0] xj,
  input  logic signed [31:0] yj,
  input  logic signed [31:0] zj,
  input  logic [31:0]        spring_const,
  input  logic [31:0]        rest_length,
  input  logic               active,
  input  logic               last_bond,
  output logic               empty,
  input  logic               pop,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_y,
  output logic signed [47:0] force_z,
  output logic [47:0]        bond_energy,
  output logic [47:0]        energy_total,
  output logic               done_res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [hbf_pkg::LW-1:0] lambda_weight;
  logic                   q_push, q_pop, q_full, q_valid;
  hbf_pkg::entry_t        q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda_weight <= hbf_pkg::LAMBDA_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == hbf_pkg::REG_LAMBDA)) begin
      lambda_weight <= pwdata[hbf_pkg::LW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == hbf_pkg::REG_LAMBDA) ? 32'(lambda_weight) : '0;
  assign full   = q_full;

  hbf_front u_front (
    .push         (push),
    .q_full       (q_full),
    .xi           (xi),
    .yi           (yi),
    .zi           (zi),
    .xj           (xj),
    .yj           (yj),
    .zj           (zj),
    .spring_const (spring_const),
    .rest_length  (rest_length),
    .active       (active),
    .last_bond    (last_bond),
    .q_push       (q_push),
    .q_entry      (q_in)
  );

  hbf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_in),
    .rd    (q_pop),
    .rdata (q_out),
    .full  (q_full),
    .valid (q_valid)
  );

  hbf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (q_out),
    .q_pop         (q_pop),
    .lambda_weight (lambda_weight),
    .pop           (pop),
    .empty         (empty),
    .force_x       (force_x),
    .force_y       (force_y),
    .force_z       (force_z),
    .bond_energy   (bond_energy),
    .energy_total  (energy_total),
    .done_res      (done_res)
  );

endmodule

[tb/sv/harmonic_bond_force_test.sv]
// Self-checking testbench for the harmonic bond force block with a scoreboard class.
module harmonic_bond_force_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] xi, yi, zi, xj, yj, zj;
    logic [31:0]        kb, b0;
    logic               active, last;
  } bond_t;

  typedef struct {
    logic [47:0] fx, fy, fz, energy, total;
    logic        done;
  } force_beat_t;

  class bond_ledger;
    force_beat_t  pending_forces[$];
    logic [47:0]  energy_sum;
    logic [16:0]  lambda;
    int           errors;

    function new();
      energy_sum = '0;
      lambda     = hbf_pkg::LAMBDA_RESET;
      errors     = 0;
    endfunction

    function automatic logic [47:0] axis_force(logic [127:0] base, bit neg_db, longint d,
                                               logic [127:0] b);
      logic [127:0] m;
      logic [127:0] dm;
      bit           neg;
      dm  = (d < 0) ? 128'(-d) : 128'(d);
      neg = neg_db ^ (d < 0);
      m   = ((base * dm) / b) >> hbf_pkg::F_SHIFT;
      if (m == 0) return '0;
      if (neg) return -48'((m > 128'h8000_0000_0000) ? 128'h8000_0000_0000 : m);
      return 48'((m > 128'h7FFF_FFFF_FFFF) ? 128'h7FFF_FFFF_FFFF : m);
    endfunction

    function void note_bond(bond_t bd);
      force_beat_t  r;
      longint       dx, dy, dz, db;
      logic [127:0] sq, c, bl, dbm, e, base;
      logic [48:0]  s;
      r = '{default: '0};
      r.done = bd.last;
      if (bd.active) begin
        dx = longint'(bd.xj) - longint'(bd.xi);
        dy = longint'(bd.yj) - longint'(bd.yi);
        dz = longint'(bd.zj) - longint'(bd.zi);
        sq = 128'(dx * dx);
        sq = sq + 128'(dy * dy) + 128'(dz * dz);
        if (dx * dx < 0 || dy * dy < 0 || dz * dz < 0) begin
          sq = 128'(unsigned'(dx * dx)) + 128'(unsigned'(dy * dy)) + 128'(unsigned'(dz * dz));
        end
        bl = '0;
        for (int k = 33; k >= 0; k--) begin
          c = bl | (128'(1) << k);
          if (c * c <= sq) bl = c;
        end
        db  = longint'(bl) - longint'({32'b0, bd.b0});
        dbm = (db < 0) ? 128'(-db) : 128'(db);
        e   = dbm * dbm;
        e   = (e * 128'(bd.kb)) >> hbf_pkg::E_SHIFT;
        r.energy = (e > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : 48'(e);
        if (bl != 0) begin
          base = dbm * 128'(lambda);
          base = base * 128'(bd.kb);
          r.fx = axis_force(base, db < 0, dx, bl);
          r.fy = axis_force(base, db < 0, dy, bl);
          r.fz = axis_force(base, db < 0, dz, bl);
        end
        s = 49'(energy_sum) + 49'(r.energy);
        energy_sum = s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
      end
      r.total = energy_sum;
      if (bd.last) energy_sum = '0;
      pending_forces.push_back(r);
    endfunction

    function void check_result(force_beat_t act);
      force_beat_t x;
      if (pending_forces.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      x = pending_forces.pop_front();
      if (act.fx !== x.fx) begin
        $error("force_x expected %h got %h", x.fx, act.fx); errors++;
      end
      if (act.fy !== x.fy) begin
        $error("force_y expected %h got %h", x.fy, act.fy); errors++;
      end
      if (act.fz !== x.fz) begin
        $error("force_z expected %h got %h", x.fz, act.fz); errors++;
      end
      if (act.energy !== x.energy) begin
        $error("bond_energy expected %h got %h", x.energy, act.energy); errors++;
      end
      if (act.total !== x.total) begin
        $error("energy_total expected %h got %h", x.total, act.total); errors++;
      end
      if (act.done !== x.done) begin
        $error("done_res expected %b got %b", x.done, act.done); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [31:0] xi = '0, yi = '0, zi = '0, xj = '0, yj = '0, zj = '0;
  logic [31:0] spring_const = '0, rest_length = '0;
  logic active = 1'b0, last_bond = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [47:0] force_x, force_y, force_z;
  logic [47:0] bond_energy, energy_total;
  logic done_res;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bond_ledger ledger = new();
  bit steady = 1'b0;

  harmonic_bond_force u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      ledger.check_result('{force_x, force_y, force_z, bond_energy, energy_total, done_res});
    end
  end

  initial begin : receiver
    int hold;
    int beats;
    hold  = 0;
    beats = 0;
    forever begin
      @(negedge clk);
      if (pop && !empty && !rst) beats++;
      if (beats == 400 && hold == 0) begin
        hold  = 300;
        beats = beats + 1;
      end
      if (hold > 0) begin
        pop  = 1'b0;
        hold = hold - 1;
      end else if (steady || $urandom_range(0, 99) < 75) begin
        pop = 1'b1;
      end else begin
        pop  = 1'b0;
        hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      end
    end
  end

  task automatic send_bond(bond_t bd);
    int gap;
    {xi, yi, zi, xj, yj, zj} = {bd.xi, bd.yi, bd.zi, bd.xj, bd.yj, bd.zj};
    spring_const = bd.kb;
    rest_length  = bd.b0;
    active       = bd.active;
    last_bond    = bd.last;
    push         = 1'b1;
    do @(posedge clk); while (full);
    ledger.note_bond(bd);
    @(negedge clk);
    gap = 0;
    if (!steady && $urandom_range(0, 99) >= 70) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    push = 1'b0;
    while (ledger.pending_forces.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_lambda(logic [16:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 3'(4 * hbf_pkg::REG_LAMBDA);
    pwdata  = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    ledger.lambda = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic bond_t random_bond();
    bond_t bd;
    int    pick;
    pick = $urandom_range(0, 9);
    bd.xi = $urandom; bd.yi = $urandom; bd.zi = $urandom;
    bd.xj = $urandom; bd.yj = $urandom; bd.zj = $urandom;
    bd.kb = $urandom;
    bd.b0 = $urandom;
    if (pick < 6) begin
      bd.xj = bd.xi + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      bd.yj = bd.yi + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      bd.zj = bd.zi + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      bd.b0 = $urandom_range(0, 1 << 21);
    end else if (pick == 6) begin
      {bd.xj, bd.yj, bd.zj} = {bd.xi, bd.yi, bd.zi};
    end else if (pick == 7) begin
      bd.xi = $signed($urandom_range(0, 64)) - 32;
      bd.xj = $signed($urandom_range(0, 64)) - 32;
      bd.yj = bd.yi;
      bd.zj = bd.zi;
      bd.b0 = $urandom_range(0, 40);
      bd.kb = $urandom_range(0, 1 << 20);
    end
    bd.active = ($urandom_range(0, 9) != 0);
    bd.last   = ($urandom_range(0, 7) == 0);
    return bd;
  endfunction

  initial begin : stimulus
    bond_t       dir[$];
    logic [16:0] lambdas[5];
    lambdas = '{17'd0, 17'h1FFFF, 17'd65537, 17'd1, 17'($urandom_range(0, 131071))};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_lambda(hbf_pkg::LAMBDA_RESET);

    dir.push_back('{0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0001_0000, 1'b1, 1'b0});
    dir.push_back('{5, 5, 5, 5, 5, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0});
    dir.push_back('{-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                    32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                    32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0});
    dir.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                    -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                    32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0});
    dir.push_back('{0, 0, 0, 32'h0002_0000, 0, 0, 32'h0010_0000, 32'h0001_0000, 1'b1, 1'b0});
    dir.push_back('{0, 0, 0, 0, -32'sh0001_0000, 0, 32'h0010_0000, 32'hFFFF_FFFF, 1'b1, 1'b0});
    dir.push_back('{0, 0, 0, 0, 0, 32'h0003_0000, 32'h0, 32'h0001_0000, 1'b1, 1'b1});
    dir.push_back('{1, 2, 3, 4, 5, 6, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0});
    dir.push_back('{1, 2, 3, 4, 5, 6, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1});
    dir.push_back('{0, 0, 0, 1, 0, 0, 32'h1, 32'h1, 1'b1, 1'b0});
    dir.push_back('{-32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0});
    dir.push_back('{-32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0});
    dir.push_back('{-32'sh8000_0000, -32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0,
                    32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0});
    dir.push_back('{0, 0, 0, 0, 0, 0, 32'h0, 32'h0, 1'b1, 1'b1});
    dir.push_back('{0, 0, 0, 3, 4, 0, 32'h0001_0000, 32'h0, 1'b1, 1'b1});
    foreach (dir[k]) send_bond(dir[k]);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      write_lambda(lambdas[p]);
      steady = (p == 2);
      for (int n = 0; n < 267; n++) begin
        if (p == 3 && n == 100) wait_idle();
        send_bond(random_bond());
      end
      wait_idle();
    end
    steady = 1'b0;
    if (ledger.errors == 0) begin
      $display("harmonic_bond_force_test: clean");
    end else begin
      $display("harmonic_bond_force_test: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #8ms;
    $display("harmonic_bond_force_test: errors");
    $finish;
  end
endmodule
